[src/assert_macros.svh]
// Assertion macros shared by the RTL; they are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, switched off while reset is held.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that must also hold while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[src/arb_pkg.sv]
// Shared types and constants for the audio ring buffer block.
`timescale 1ns / 1ps

package arb_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GAIN       = 2'd0,
        REG_PAUSED     = 2'd1,
        REG_KEEP_ALIVE = 2'd2
    } reg_idx_t;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SAMPLE_W    = 16;
    localparam int FILL_W      = 20;
    localparam int GAIN_FRAC   = 14;
    localparam int NEAR_MARGIN = 2048;

    localparam logic [15:0]        GAIN_RESET      = 16'h4000;
    localparam logic [15:0]        MAX_GAIN        = 16'h8000;
    localparam logic [15:0]        KEEP_ALIVE_BITS = 16'h0005;
    localparam logic signed [32:0] ROUND_BIAS      = 33'sd16383;
    localparam logic signed [18:0] SAT_HIGH        = 19'sd32767;
    localparam logic signed [18:0] SAT_LOW         = -19'sd32768;

    // One input request
    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       block_last;
    } in_t;

    // One result
    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               from_ring;
        logic               block_end;
        logic [15:0]        level_peak;
        logic [19:0]        fill_count;
        logic               near_full;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic write_hi;
        logic multiply;
        logic scale;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_full;
        logic out_free;
    } dp_status_t;

endpackage

[src/arb_ctrl.sv]
// Sequencing state machine for the audio ring buffer.
`timescale 1ns / 1ps

module arb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  arb_pkg::op_t          item_op,
    input  arb_pkg::dp_status_t   status,
    output logic                  item_stall,
    output arb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRHI  = 5'b00010,
        S_MUL   = 5'b00100,
        S_SCALE = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (item_op == arb_pkg::OP_PUSH && status.frame_full)
                    begin
                        state_next = S_WRHI;
                    end
                    else if (item_op == arb_pkg::OP_PULL)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_WRHI:
            begin
                cmd.write_hi = 1'b1;
                state_next   = S_FIN;
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait here while the result register is occupied and stalled
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

[src/arb_dp.sv]
// Datapath: sample ring memory, frame assembly, gain, peak and result register.
`timescale 1ns / 1ps

module arb_dp #(
    parameter int RING_DEPTH = 524288
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  arb_pkg::in_t                      item,
    input  arb_pkg::ctrl_cmd_t                cmd,
    output arb_pkg::dp_status_t               status,
    input  logic                              cfg_valid,
    input  logic [arb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output arb_pkg::out_t                     result
);

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int NearLimit = RING_DEPTH - arb_pkg::NEAR_MARGIN;

    // Sample memory, no reset
    logic [arb_pkg::SAMPLE_W-1:0] mem [RING_DEPTH];

    // Ring state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [23:0]      partial_reg, partial_next;
    logic [1:0]       pcount_reg, pcount_next;
    logic             popped_reg, popped_next;
    logic [15:0]      peak_reg, peak_next;

    // Configuration
    logic [15:0]      gain_reg;
    logic             paused_reg;
    logic             keep_reg;

    // Item pipeline payload
    arb_pkg::in_t              item_reg;
    logic [15:0]               rd_data_reg;
    logic signed [32:0]        prod_reg, prod_next;
    logic signed [15:0]        scaled_reg, scaled_next;
    arb_pkg::out_t             result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    // Memory port
    logic             mem_we;
    logic [PTR_W-1:0] mem_addr;
    logic [15:0]      mem_wdata;
    logic             store_en;

    // Gain and result temporaries
    logic signed [15:0] samp;
    logic [15:0]        gain_eff;
    logic signed [32:0] samp_ext;
    logic signed [32:0] gain_ext;
    logic signed [32:0] adj;
    logic signed [18:0] quo;
    logic [15:0]        mag;
    logic [15:0]        peak_max;
    logic [15:0]        keep_bits;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Ring pointers, fill count and frame assembly
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        held_next    = held_reg;
        partial_next = partial_reg;
        pcount_next  = pcount_reg;
        popped_next  = popped_reg;
        store_en     = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = rd_ptr_reg;
        mem_wdata    = partial_reg[15:0];
        if (cmd.accept)
        begin
            unique case (item.op)
                arb_pkg::OP_PUSH:
                begin
                    if (pcount_reg == 2'd3)
                    begin
                        // frame complete: low sample now, high sample next cycle
                        mem_we   = 1'b1;
                        mem_addr = wr_ptr_reg;
                        store_en = 1'b1;
                    end
                    else
                    begin
                        unique case (pcount_reg)
                            2'd0:    partial_next[7:0]   = item.data_byte;
                            2'd1:    partial_next[15:8]  = item.data_byte;
                            default: partial_next[23:16] = item.data_byte;
                        endcase
                        pcount_next = pcount_reg + 2'd1;
                    end
                end
                arb_pkg::OP_PULL:
                begin
                    if (held_reg != '0)
                    begin
                        popped_next = 1'b1;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                        held_next   = held_reg - CNT_W'(1);
                    end
                    else
                    begin
                        popped_next = 1'b0;
                    end
                end
                arb_pkg::OP_CLEAR:
                begin
                    wr_ptr_next  = '0;
                    rd_ptr_next  = '0;
                    held_next    = '0;
                    partial_next = '0;
                    pcount_next  = '0;
                end
                arb_pkg::OP_NONE:
                begin
                end
            endcase
        end
        else if (cmd.write_hi)
        begin
            mem_we       = 1'b1;
            mem_addr     = wr_ptr_reg;
            mem_wdata    = {item_reg.data_byte, partial_reg[23:16]};
            store_en     = 1'b1;
            partial_next = '0;
            pcount_next  = '0;
        end
        // a store into a full ring drops the oldest sample
        if (store_en)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (held_reg == CNT_W'(RING_DEPTH))
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
            else
            begin
                held_next = held_reg + CNT_W'(1);
            end
        end
    end

    // Gain multiply, truncation toward zero and saturation
    always_comb
    begin
        samp     = (popped_reg && !paused_reg) ? $signed(rd_data_reg) : 16'sd0;
        gain_eff = (gain_reg > arb_pkg::MAX_GAIN) ? arb_pkg::MAX_GAIN : gain_reg;
        samp_ext = 33'(samp);
        gain_ext = $signed({17'd0, gain_eff});
        prod_next = cmd.multiply ? samp_ext * gain_ext : prod_reg;

        adj = prod_reg + (prod_reg[32] ? arb_pkg::ROUND_BIAS : 33'sd0);
        quo = adj[32:arb_pkg::GAIN_FRAC];
        scaled_next = scaled_reg;
        if (cmd.scale)
        begin
            priority if (quo > arb_pkg::SAT_HIGH)
            begin
                scaled_next = 16'sh7FFF;
            end
            else if (quo < arb_pkg::SAT_LOW)
            begin
                scaled_next = -16'sh8000;
            end
            else
            begin
                scaled_next = quo[15:0];
            end
        end
    end

    // Result assembly and peak tracking
    always_comb
    begin
        mag       = scaled_reg[15] ? 16'(-scaled_reg) : 16'(scaled_reg);
        peak_max  = (mag > peak_reg) ? mag : peak_reg;
        keep_bits = (item_reg.block_last && keep_reg) ? arb_pkg::KEEP_ALIVE_BITS : 16'd0;
        peak_next = peak_reg;

        result_next            = result_reg;
        result_valid_next      = result_valid_reg && result_stall;
        if (cmd.finish)
        begin
            result_valid_next      = 1'b1;
            result_next            = '0;
            result_next.fill_count = arb_pkg::FILL_W'(held_reg);
            result_next.near_full  = (held_reg >= CNT_W'(NearLimit));
            if (item_reg.op == arb_pkg::OP_PULL)
            begin
                result_next.out_sample = $signed(16'(scaled_reg) | keep_bits);
                result_next.from_ring  = popped_reg;
                if (item_reg.block_last)
                begin
                    result_next.block_end  = 1'b1;
                    result_next.level_peak = peak_max;
                    peak_next              = '0;
                end
                else
                begin
                    peak_next = peak_max;
                end
            end
        end
    end

    // Single-port memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        result_reg <= result_next;
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            held_reg         <= '0;
            partial_reg      <= '0;
            pcount_reg       <= '0;
            popped_reg       <= 1'b0;
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
            gain_reg         <= arb_pkg::GAIN_RESET;
            paused_reg       <= 1'b0;
            keep_reg         <= 1'b0;
        end
        else
        begin
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            held_reg         <= held_next;
            partial_reg      <= partial_next;
            pcount_reg       <= pcount_next;
            popped_reg       <= popped_next;
            peak_reg         <= peak_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                unique case (arb_pkg::reg_idx_t'(cfg_index))
                    arb_pkg::REG_GAIN:       gain_reg   <= cfg_data;
                    arb_pkg::REG_PAUSED:     paused_reg <= cfg_data[0];
                    arb_pkg::REG_KEEP_ALIVE: keep_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign status.frame_full = (pcount_reg == 2'd3);
    assign status.out_free   = !result_valid_reg || !result_stall;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

endmodule

[src/audio_ring_buffer_with_gain_peak.sv]
// Top level: audio ring buffer with gain, peak tracking and keep-alive marking.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   item     | item_valid / item_stall   | item   (arb_pkg::in_t)
//   result   | result_valid / result_stall | result (arb_pkg::out_t)
//   cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One request at a time: a byte push, clear or no-op is accepted and then finished,
// a push that completes a frame adds a second sample write on the single memory port,
// and a pull goes through memory read, gain multiply, scale and saturate, and result.
// A result waits in the output register; a stalled result holds the next
// request in its last cycle. Reset is asynchronous and empties the ring.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_ring_buffer_with_gain_peak #(
    parameter int RING_DEPTH = 524288
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  arb_pkg::in_t                      item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output arb_pkg::out_t                     result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    arb_pkg::ctrl_cmd_t  cmd;
    arb_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    arb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.op),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    arb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Only one request in flight
    `ASSERT_PROP(a_one_in_flight, (item_valid && !item_stall) |=> item_stall, "second request accepted while busy")
    // A finished request always lands in the result register
    `ASSERT_PROP(a_finish_loads, cmd.finish |=> result_valid, "finished request produced no result")
    // Nonzero samples only come from the ring or from keep-alive marking
    `ASSERT_PROP(a_silent_result, (result_valid && !result.from_ring && !result.block_end) |-> (result.out_sample == 16'sd0), "nonzero sample without ring data")

endmodule

[bench/tb.sv]
// Self-checking bench for the audio ring buffer with gain and peak tracking.
`timescale 1ns / 1ps

module tb;

    // Ring depth used by the bench
    localparam int RING_SIZE = 4096;
    localparam int LONG_HOLD = 300;
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_stall;
    arb_pkg::in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    arb_pkg::out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [arb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [arb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    audio_ring_buffer_with_gain_peak #(
        .RING_DEPTH(RING_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Requests waiting to be offered, and results owed by the block
    arb_pkg::in_t pcm_requests[$];
    arb_pkg::out_t ring_results_due[$];

    int requests_queued = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    bit idle_on = 1'b0;
    int hold_orders = 0;

    // Shadow of the block: ring contents, pointers, frame assembly, peak, registers
    logic [15:0] ring_mem [RING_SIZE];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;
    int unsigned held = 0;
    logic [23:0] frag_bytes = '0;
    int unsigned frag_count = 0;
    int unsigned block_peak = 0;
    logic [15:0] gain_reg = arb_pkg::GAIN_RESET;
    logic paused_reg = 1'b0;
    logic keep_alive_reg = 1'b0;

    // Tallies for the closing summary
    int popped_total = 0;
    int empty_pulls = 0;
    int blocks_ended = 0;
    int overwritten = 0;
    int saturated = 0;
    int near_full_seen = 0;

    function automatic void store_word(logic [15:0] w);
        ring_mem[wr_ptr] = w;
        wr_ptr = (wr_ptr + 1 >= RING_SIZE) ? 0 : wr_ptr + 1;
        // Full ring: the oldest sample is dropped
        if (held >= RING_SIZE)
        begin
            rd_ptr = (rd_ptr + 1 >= RING_SIZE) ? 0 : rd_ptr + 1;
            overwritten++;
        end
        else
        begin
            held++;
        end
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic arb_pkg::out_t predict_ring_output(arb_pkg::in_t req);
        arb_pkg::out_t r;
        int s;
        int p;
        int g;
        int mag;
        logic [31:0] frame;
        r = '0;
        case (req.op)
            arb_pkg::OP_PUSH:
            begin
                if (frag_count < 3)
                begin
                    frag_bytes[8*frag_count +: 8] = req.data_byte;
                    frag_count++;
                end
                else
                begin
                    frame = {req.data_byte, frag_bytes};
                    store_word(frame[15:0]);
                    store_word(frame[31:16]);
                    frag_bytes = '0;
                    frag_count = 0;
                end
            end
            arb_pkg::OP_PULL:
            begin
                s = 0;
                if (held > 0)
                begin
                    s = $signed(ring_mem[rd_ptr]);
                    rd_ptr = (rd_ptr + 1 >= RING_SIZE) ? 0 : rd_ptr + 1;
                    held--;
                    r.from_ring = 1'b1;
                    popped_total++;
                end
                else
                begin
                    empty_pulls++;
                end
                if (paused_reg)
                    s = 0;
                // Q2.14 gain clamped at 2.0, truncate toward zero, saturate
                g = (gain_reg > arb_pkg::MAX_GAIN) ? int'(arb_pkg::MAX_GAIN) : int'(gain_reg);
                p = (s * g) / (1 << arb_pkg::GAIN_FRAC);
                if (p > 32767 || p < -32768)
                    saturated++;
                if (p > 32767)
                    p = 32767;
                if (p < -32768)
                    p = -32768;
                mag = (p < 0) ? -p : p;
                if (mag > block_peak)
                    block_peak = mag;
                r.out_sample = p[15:0];
                if (req.block_last)
                begin
                    r.block_end = 1'b1;
                    r.level_peak = block_peak[15:0];
                    block_peak = 0;
                    blocks_ended++;
                    if (keep_alive_reg)
                        r.out_sample = r.out_sample | arb_pkg::KEEP_ALIVE_BITS;
                end
            end
            arb_pkg::OP_CLEAR:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
                held = 0;
                frag_bytes = '0;
                frag_count = 0;
            end
            default: ;
        endcase
        r.fill_count = held[19:0];
        r.near_full = (held + arb_pkg::NEAR_MARGIN >= RING_SIZE);
        if (r.near_full)
            near_full_seen++;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Request driver: holds a stalled request, otherwise idles or offers the next one
    always @(posedge clk)
    begin : drive_requests
        logic offer;
        int gap_left;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                ring_results_due.push_back(predict_ring_output(item));
                requests_taken++;
            end
            offer = item_valid && item_stall;
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 7);
                end
                else if (pcm_requests.size() > 0)
                begin
                    item <= pcm_requests.pop_front();
                    offer = 1'b1;
                end
            end
            item_valid <= offer;
        end
        else
        begin
            gap_left = 0;
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk)
    begin : watch_results
        arb_pkg::out_t want;
        int stall_left;
        int hold_left;
        int hold_seen;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (ring_results_due.size() == 0)
                begin
                    mismatches++;
                    $error("result arrived with nothing expected");
                end
                else
                begin
                    want = ring_results_due.pop_front();
                    check_field("out_sample", int'(want.out_sample),
                                int'(result.out_sample));
                    check_field("from_ring", int'(want.from_ring), int'(result.from_ring));
                    check_field("block_end", int'(want.block_end), int'(result.block_end));
                    check_field("level_peak", int'(want.level_peak),
                                int'(result.level_peak));
                    check_field("fill_count", int'(want.fill_count),
                                int'(result.fill_count));
                    check_field("near_full", int'(want.near_full), int'(result.near_full));
                    results_checked++;
                end
            end
            // Long hold-off when asked, otherwise random short stalls
            if (hold_seen != hold_orders)
            begin
                hold_seen = hold_orders;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
        else
        begin
            stall_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end
    end

    task automatic queue_req(arb_pkg::op_t op, logic [7:0] b, logic last);
        arb_pkg::in_t r;
        r.op = op;
        r.data_byte = b;
        r.block_last = last;
        pcm_requests.push_back(r);
        requests_queued++;
    endtask

    // Four bytes forming one stereo frame, little-endian
    task automatic push_frame(logic [31:0] frame);
        for (int i = 0; i < 4; i++)
            queue_req(arb_pkg::OP_PUSH, frame[8*i +: 8], 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_pull_block(int n);
        for (int i = 0; i < n; i++)
            queue_req(arb_pkg::OP_PULL, 8'($urandom_range(0, 255)), i == n - 1);
    endtask

    // Config write; called only while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            arb_pkg::REG_GAIN:       gain_reg = val;
            arb_pkg::REG_PAUSED:     paused_reg = val[0];
            arb_pkg::REG_KEEP_ALIVE: keep_alive_reg = val[0];
            default: ;
        endcase
    endtask

    // Wait until every request is taken and every result checked
    task automatic quiesce();
        while (!(requests_taken == requests_queued && results_checked == requests_taken))
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly whole frames and render blocks, with broken frames and noise mixed in
    task automatic random_phase(int n);
        int target;
        int kind;
        int k;
        target = requests_queued + n;
        while (requests_queued < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                push_frame($urandom);
            end
            else if (kind < 80)
            begin
                queue_pull_block($urandom_range(1, 6));
            end
            else if (kind < 88)
            begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    queue_req(arb_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    queue_req(arb_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    queue_req(arb_pkg::OP_PULL, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            else if (kind < 92)
            begin
                queue_req(arb_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
            else if (kind < 96)
            begin
                queue_req(arb_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                queue_req(arb_pkg::OP_PULL, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pull, full-scale samples, partial frame, clear, no-op
        queue_req(arb_pkg::OP_PULL, 8'h00, 1'b1);
        push_frame(32'h7FFF_8000);
        queue_req(arb_pkg::OP_NONE, 8'h00, 1'b0);
        queue_req(arb_pkg::OP_PULL, 8'h00, 1'b0);
        queue_req(arb_pkg::OP_PULL, 8'hFF, 1'b1);
        queue_req(arb_pkg::OP_PUSH, 8'hAA, 1'b0);
        queue_req(arb_pkg::OP_PUSH, 8'h55, 1'b1);
        queue_req(arb_pkg::OP_PUSH, 8'hFF, 1'b0);
        queue_req(arb_pkg::OP_CLEAR, 8'h00, 1'b0);
        queue_req(arb_pkg::OP_PULL, 8'h00, 1'b1);
        push_frame(32'hFFFE_0001);
        queue_req(arb_pkg::OP_PULL, 8'h00, 1'b0);
        queue_req(arb_pkg::OP_PULL, 8'h00, 1'b1);
        queue_req(arb_pkg::OP_NONE, 8'hFF, 1'b1);
        quiesce();

        // Partly fill the ring, then drain it past empty
        idle_on = 1'b1;
        for (int f = 0; f < 100; f++)
        begin
            push_frame($urandom);
            if (f % 10 == 9)
                queue_pull_block(4);
        end
        quiesce();
        idle_on = 1'b0;
        for (int i = 0; i < 200; i++)
            queue_req(arb_pkg::OP_PULL, 8'($urandom_range(0, 255)), i % 32 == 31);
        quiesce();

        // Zero gain, keep-alive marking
        write_reg(arb_pkg::REG_GAIN, 16'h0000);
        write_reg(arb_pkg::REG_KEEP_ALIVE, 16'h0001);
        idle_on = 1'b1;
        random_phase(110);
        quiesce();

        // Maximum gain with the receiver holding off for a long stretch
        write_reg(arb_pkg::REG_GAIN, arb_pkg::MAX_GAIN);
        write_reg(arb_pkg::REG_KEEP_ALIVE, 16'h0000);
        hold_orders++;
        random_phase(110);
        quiesce();

        // Gain register above 2.0 is clamped
        write_reg(arb_pkg::REG_GAIN, 16'hFFFF);
        write_reg(arb_pkg::REG_KEEP_ALIVE, 16'h0001);
        idle_on = 1'b0;
        random_phase(110);
        quiesce();

        // Paused: samples consumed but silenced
        write_reg(arb_pkg::REG_GAIN, 16'h2000);
        write_reg(arb_pkg::REG_PAUSED, 16'h0001);
        idle_on = 1'b1;
        random_phase(100);
        quiesce();

        write_reg(arb_pkg::REG_PAUSED, 16'h0000);
        write_reg(arb_pkg::REG_GAIN, 16'($urandom_range(1, 32767)));
        write_reg(arb_pkg::REG_KEEP_ALIVE, 16'($urandom_range(0, 1)));
        random_phase(110);
        quiesce();

        // Unused register index is ignored; last stretch runs without idling
        write_reg(REG_SPARE, 16'h1234);
        write_reg(arb_pkg::REG_GAIN, 16'h8001);
        idle_on = 1'b0;
        random_phase(110);
        quiesce();
        repeat (20) @(posedge clk);

        if (ring_results_due.size() != 0)
        begin
            mismatches++;
            $error("%0d results never arrived", ring_results_due.size());
        end
        $display("Covered %0d requests: %0d samples popped, %0d empty pulls, %0d blocks ended.",
                 requests_taken, popped_total, empty_pulls, blocks_ended);
        $display("Ring overwrote %0d samples, %0d saturated outputs, near-full on %0d results.",
                 overwritten, saturated, near_full_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
